// ===== rtl/sha1sh_pkg.sv =====
package sha1sh_pkg;

    localparam int BLK_BITS    = 512;
    localparam int WORD_BITS   = 32;
    localparam int FILL_BITS   = 6;
    localparam int CNT_BITS    = 61;
    localparam int LEN_BITS    = 64;
    localparam int CHAIN_WORDS = 5;
    localparam int ROUNDS      = 80;

    localparam logic [FILL_BITS-1:0] FILL_LAST  = 6'd63;
    localparam logic [FILL_BITS-1:0] FILL_LEN   = 6'd56;
    localparam logic [2:0]           WORD_LAST  = 3'(CHAIN_WORDS - 1);
    localparam logic [6:0]           ROUND_LAST = 7'(ROUNDS - 1);

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [WORD_BITS-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_BITS-1:0] IV1 = 32'hEFCDAB89;
    localparam logic [WORD_BITS-1:0] IV2 = 32'h98BADCFE;
    localparam logic [WORD_BITS-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_BITS-1:0] IV4 = 32'hC3D2E1F0;

    localparam logic [WORD_BITS-1:0] RC0_RST = 32'h5A827999;
    localparam logic [WORD_BITS-1:0] RC1_RST = 32'h6ED9EBA1;
    localparam logic [WORD_BITS-1:0] RC2_RST = 32'h8F1BBCDC;
    localparam logic [WORD_BITS-1:0] RC3_RST = 32'hCA62C1D6;

    // configuration register indexes
    localparam logic [2:0] REG_RC0  = 3'd0;
    localparam logic [2:0] REG_RC1  = 3'd1;
    localparam logic [2:0] REG_RC2  = 3'd2;
    localparam logic [2:0] REG_RC3  = 3'd3;
    localparam logic [2:0] REG_MASK = 3'd4;

    typedef enum logic [1:0] {
        SEL_BYTE = 2'd0,
        SEL_MARK = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } t_shift_sel;

    typedef enum logic [1:0] {
        GRP_CH  = 2'd0,
        GRP_PAR = 2'd1,
        GRP_MAJ = 2'd2,
        GRP_PR2 = 2'd3
    } t_rgrp;

    typedef struct packed {
        logic       shift;
        t_shift_sel sel;
        logic       count;
        logic       load;
        logic       round;
        t_rgrp      rgrp;
        logic       add;
        logic       restart;
        logic       out_load;
        logic       out_err;
        logic [2:0] word_sel;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic fill_ge56;
        logic fill_eq56;
        logic ovf;
        logic cnt_max;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/sha1_stream_hash_top.sv =====
// streaming sha-1: one byte per transaction, accepted only while the controller is idle
// a full 64-byte block: load, the rounds on one shared round unit, then the chain add
// end of message: mark, zero and length padding plus one or two block compressions,
// then 5 digest words (or one error word) from a registered output stage
// no byte taken mid-compression; synchronous active-low reset to the initial vector
module sha1_stream_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // message_end
    input  logic [0:0]  i_s_axis_tuser,   // [0] byte_present
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic        o_m_axis_tlast,   // word_last
    output logic [0:0]  o_m_axis_tuser    // [0] status
);

    sha1sh_pkg::t_cmd  cmd;
    sha1sh_pkg::t_stat stat;

    sha1sh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_present (i_s_axis_tuser[0]),
        .i_in_end     (i_s_axis_tlast),
        .o_in_ready   (o_s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    sha1sh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_data_byte   (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_digest_word (o_m_axis_tdata),
        .o_word_last   (o_m_axis_tlast),
        .o_status      (o_m_axis_tuser[0])
    );

endmodule

// ===== rtl/sha1sh_ctrl.sv =====
module sha1sh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_present,
    input  logic               i_in_end,
    output logic               o_in_ready,
    input  sha1sh_pkg::t_stat  i_stat,
    output sha1sh_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_ROUND = 9'b000000100,
        S_ADD   = 9'b000001000,
        S_MARK  = 9'b000010000,
        S_ZERO  = 9'b000100000,
        S_LEN   = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_ERR   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_PAD1  = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic       r_end, n_end;
    logic       r_to64, n_to64;
    logic [6:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;
    logic       take;
    logic       ovf_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_end   <= 1'b0;
            r_to64  <= 1'b0;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_end   <= n_end;
            r_to64  <= n_to64;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_end      = r_end;
        n_to64     = r_to64;
        n_round    = r_round;
        n_widx     = r_widx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        take       = 1'b0;
        ovf_now    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    take = i_in_present && !i_stat.ovf;
                    if (take) begin
                        o_cmd.shift = 1'b1;
                        o_cmd.sel   = sha1sh_pkg::SEL_BYTE;
                        o_cmd.count = 1'b1;
                    end
                    ovf_now = i_stat.ovf || (take && i_stat.cnt_max);
                    if (take && i_stat.fill_last) begin
                        n_state = S_LOAD;
                        n_phase = PH_DATA;
                        n_end   = i_in_end;
                    end else if (i_in_end) begin
                        n_state = ovf_now ? S_ERR : S_MARK;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_round    = '0;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_round < 7'd20) begin
                    o_cmd.rgrp = sha1sh_pkg::GRP_CH;
                end else if (r_round < 7'd40) begin
                    o_cmd.rgrp = sha1sh_pkg::GRP_PAR;
                end else if (r_round < 7'd60) begin
                    o_cmd.rgrp = sha1sh_pkg::GRP_MAJ;
                end else begin
                    o_cmd.rgrp = sha1sh_pkg::GRP_PR2;
                end
                if (r_round == sha1sh_pkg::ROUND_LAST) begin
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                case (r_phase)
                    PH_DATA: begin
                        if (r_end) begin
                            n_state = i_stat.ovf ? S_ERR : S_MARK;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    PH_PAD1: begin
                        n_to64  = 1'b0;
                        n_state = S_ZERO;
                    end
                    default: begin
                        n_widx  = '0;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_MARK: begin
                o_cmd.shift = 1'b1;
                o_cmd.sel   = sha1sh_pkg::SEL_MARK;
                if (i_stat.fill_last) begin
                    n_phase = PH_PAD1;
                    n_state = S_LOAD;
                end else begin
                    n_to64  = i_stat.fill_ge56;
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.sel = sha1sh_pkg::SEL_ZERO;
                if (r_to64) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.fill_last) begin
                        n_phase = PH_PAD1;
                        n_state = S_LOAD;
                    end
                end else if (i_stat.fill_eq56) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_LEN: begin
                o_cmd.shift = 1'b1;
                o_cmd.sel   = sha1sh_pkg::SEL_LEN;
                if (i_stat.fill_last) begin
                    n_phase = PH_FINAL;
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.word_sel = r_widx;
                    if (r_widx == sha1sh_pkg::WORD_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.restart  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sha1sh_dp.sv =====
module sha1sh_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [7:0]        i_data_byte,
    input  sha1sh_pkg::t_cmd  i_cmd,
    output sha1sh_pkg::t_stat o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_digest_word,
    output logic              o_word_last,
    output logic              o_status
);

    // message block, doubles as the 16-word schedule window (word 0 in the top bits)
    logic [sha1sh_pkg::BLK_BITS-1:0]  r_blk;
    logic [sha1sh_pkg::FILL_BITS-1:0] r_fill;
    logic [sha1sh_pkg::CNT_BITS-1:0]  r_cnt;
    logic                             r_ovf;
    logic [31:0]                      r_chain [sha1sh_pkg::CHAIN_WORDS];
    logic [31:0]                      r_a, r_b, r_c, r_d, r_e;
    logic [31:0]                      r_rc [4];
    logic                             r_mask;
    logic                             r_ovalid;
    logic [31:0]                      r_odata;
    logic                             r_olast;
    logic                             r_ostat;

    logic [7:0]                       shift_byte;
    logic [sha1sh_pkg::LEN_BITS-1:0]  len_shifted;
    logic [31:0]                      w_cur;
    logic [31:0]                      w_mix;
    logic [31:0]                      w_new;
    logic [31:0]                      f_val;
    logic [31:0]                      k_val;
    logic [31:0]                      t_val;
    logic [31:0]                      chain_sel;

    always_comb begin
        len_shifted = {r_cnt, 3'b000} << {r_fill[2:0], 3'b000};
        case (i_cmd.sel)
            sha1sh_pkg::SEL_BYTE: shift_byte = i_data_byte;
            sha1sh_pkg::SEL_MARK: shift_byte = sha1sh_pkg::PAD_MARK;
            sha1sh_pkg::SEL_LEN:  shift_byte = len_shifted[63:56];
            default:              shift_byte = 8'h00;
        endcase
    end

    always_comb begin
        w_cur = r_blk[511:480];
        w_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
        w_new = {w_mix[30:0], w_mix[31]};
        case (i_cmd.rgrp)
            sha1sh_pkg::GRP_CH: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = r_rc[0];
            end
            sha1sh_pkg::GRP_PAR: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = r_rc[1];
            end
            sha1sh_pkg::GRP_MAJ: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = r_rc[2];
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = r_rc[3];
            end
        endcase
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_cur;
    end

    always_comb begin
        case (i_cmd.word_sel)
            3'd0:    chain_sel = r_chain[0];
            3'd1:    chain_sel = r_chain[1];
            3'd2:    chain_sel = r_chain[2];
            3'd3:    chain_sel = r_chain[3];
            3'd4:    chain_sel = r_chain[4];
            default: chain_sel = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc[0] <= sha1sh_pkg::RC0_RST;
            r_rc[1] <= sha1sh_pkg::RC1_RST;
            r_rc[2] <= sha1sh_pkg::RC2_RST;
            r_rc[3] <= sha1sh_pkg::RC3_RST;
            r_mask  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sha1sh_pkg::REG_RC0:  r_rc[0] <= i_cfg_wdata;
                sha1sh_pkg::REG_RC1:  r_rc[1] <= i_cfg_wdata;
                sha1sh_pkg::REG_RC2:  r_rc[2] <= i_cfg_wdata;
                sha1sh_pkg::REG_RC3:  r_rc[3] <= i_cfg_wdata;
                sha1sh_pkg::REG_MASK: r_mask  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // block buffer and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_blk <= {r_blk[503:0], shift_byte};
        end else if (i_cmd.load) begin
            if (r_mask) begin
                r_blk[319:288] <= '0;
                r_blk[63:32]   <= '0;
            end
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (i_cmd.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_chain[0] <= sha1sh_pkg::IV0;
            r_chain[1] <= sha1sh_pkg::IV1;
            r_chain[2] <= sha1sh_pkg::IV2;
            r_chain[3] <= sha1sh_pkg::IV3;
            r_chain[4] <= sha1sh_pkg::IV4;
            r_fill     <= '0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cmd.shift) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count) begin
                r_cnt <= r_cnt + 61'd1;
                if (&r_cnt) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= i_cmd.out_err ? 32'h0 : chain_sel;
            r_olast <= i_cmd.out_err || (i_cmd.word_sel == sha1sh_pkg::WORD_LAST);
            r_ostat <= i_cmd.out_err;
        end
    end

    assign o_stat.fill_last = (r_fill == sha1sh_pkg::FILL_LAST);
    assign o_stat.fill_ge56 = (r_fill >= sha1sh_pkg::FILL_LEN);
    assign o_stat.fill_eq56 = (r_fill == sha1sh_pkg::FILL_LEN);
    assign o_stat.ovf       = r_ovf;
    assign o_stat.cnt_max   = &r_cnt;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_odata;
    assign o_word_last   = r_olast;
    assign o_status      = r_ostat;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 600000;
    // longest quiet tail after the last digest: padding bytes plus two compressions
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        status;
    } t_digest_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tlast;   // message_end
    logic [0:0]  i_s_axis_tuser;   // [0] byte_present
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] digest_word
    logic        o_m_axis_tlast;   // word_last
    logic [0:0]  o_m_axis_tuser;   // [0] status

    // software copy of the hash engine
    logic [31:0] chain_h [sha1sh_pkg::CHAIN_WORDS];
    logic [7:0]  blk_bytes [64];
    int          fill_pos;
    logic [63:0] msg_bits;
    logic        count_ovf;
    logic [31:0] rconst [4];
    logic        mask_en;

    t_digest_beat digest_q [$];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  messages_done = 0;
    int  words_checked = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  sender_gaps   = 1'b1;
    bit  rx_stalls     = 1'b1;

    sha1_stream_hash_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_hash();
        chain_h[0] = sha1sh_pkg::IV0;
        chain_h[1] = sha1sh_pkg::IV1;
        chain_h[2] = sha1sh_pkg::IV2;
        chain_h[3] = sha1sh_pkg::IV3;
        chain_h[4] = sha1sh_pkg::IV4;
        fill_pos   = 0;
        msg_bits   = '0;
        count_ovf  = 1'b0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        if (mask_en) begin
            w[6]  = '0;
            w[14] = '0;
        end
        for (int i = 16; i < 80; i++) begin
            x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = rconst[0];
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = rconst[1];
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = rconst[2];
            end else begin
                f = b ^ c ^ d;
                k = rconst[3];
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        fill_pos = 0;
    endfunction

    // updates the engine copy for one accepted transaction and queues its digest words
    function automatic void absorb_item(logic [7:0] b, logic present, logic fin);
        t_digest_beat beat;
        if (present && !count_ovf) begin
            blk_bytes[fill_pos] = b;
            fill_pos++;
            msg_bits += 64'd8;
            if (msg_bits == '0)
                count_ovf = 1'b1;
            if (fill_pos >= 64)
                sha1_compress();
        end
        if (!fin)
            return;
        if (count_ovf) begin
            beat = '{word: '0, last: 1'b1, status: 1'b1};
            digest_q.push_back(beat);
            restart_hash();
            return;
        end
        blk_bytes[fill_pos] = sha1sh_pkg::PAD_MARK;
        fill_pos++;
        // no room for the length: close this block and pad a second one
        if (fill_pos > int'(sha1sh_pkg::FILL_LEN)) begin
            while (fill_pos < 64) begin
                blk_bytes[fill_pos] = '0;
                fill_pos++;
            end
            sha1_compress();
        end
        while (fill_pos < int'(sha1sh_pkg::FILL_LEN)) begin
            blk_bytes[fill_pos] = '0;
            fill_pos++;
        end
        for (int i = 0; i < 8; i++)
            blk_bytes[int'(sha1sh_pkg::FILL_LEN) + i] = msg_bits[63 - 8*i -: 8];
        sha1_compress();
        for (int i = 0; i < sha1sh_pkg::CHAIN_WORDS; i++) begin
            beat = '{word: chain_h[i], last: (i == sha1sh_pkg::CHAIN_WORDS - 1), status: 1'b0};
            digest_q.push_back(beat);
        end
        restart_hash();
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        absorb_item(b, present, fin);
        if (present || fin)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit sep_end);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !sep_end && n == len - 1);
        end
        if (sep_end || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_done++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (digest_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle_engine();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx <= sha1sh_pkg::REG_RC3)
            rconst[idx[1:0]] = val;
        else if (idx == sha1sh_pkg::REG_MASK)
            mask_en = val[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_stray_regs();
        for (int a = int'(sha1sh_pkg::REG_MASK) + 1; a < 8; a++)
            write_reg(3'(a), $urandom());
    endtask

    task automatic run_random_messages(input int item_target, input int msg_min);
        int first_items;
        int first_msgs;
        int pick;
        int len;
        first_items = items_sent;
        first_msgs  = messages_done;
        while (items_sent - first_items < item_target || messages_done - first_msgs < msg_min)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                len = $urandom_range(0, 8);
            else if (pick < 19)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(120, 130);
            send_message(len, $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end
    endtask

    task automatic test_basic_messages();
        // empty message: end mark with no byte
        send_item(8'h00, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        // no byte and no end is a no-op
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        messages_done += 5;
    endtask

    task automatic test_padding_boundaries();
        // 56 leaves no room for the length, 63 puts the mark in the last byte of the block
        send_message(56, 1'b0);
        send_message(63, 1'b0);
    endtask

    task automatic test_default_constants();
        run_random_messages(8, 2);
    endtask

    task automatic test_zero_constants_masked();
        settle_engine();
        write_reg(sha1sh_pkg::REG_RC0, 32'h0000_0000);
        write_reg(sha1sh_pkg::REG_RC1, 32'h0000_0000);
        write_reg(sha1sh_pkg::REG_RC2, 32'h0000_0000);
        write_reg(sha1sh_pkg::REG_RC3, 32'h0000_0000);
        write_reg(sha1sh_pkg::REG_MASK, 32'hFFFF_FFFF);
        write_stray_regs();
        run_random_messages(8, 2);
    endtask

    task automatic test_ones_constants();
        settle_engine();
        write_reg(sha1sh_pkg::REG_RC0, 32'hFFFF_FFFF);
        write_reg(sha1sh_pkg::REG_RC1, 32'hFFFF_FFFF);
        write_reg(sha1sh_pkg::REG_RC2, 32'hFFFF_FFFF);
        write_reg(sha1sh_pkg::REG_RC3, 32'hFFFF_FFFF);
        write_reg(sha1sh_pkg::REG_MASK, 32'hFFFF_FFFE);
        write_stray_regs();
        run_random_messages(8, 2);
    endtask

    task automatic test_random_constants_no_idle();
        settle_engine();
        write_reg(sha1sh_pkg::REG_RC0, $urandom());
        write_reg(sha1sh_pkg::REG_RC1, $urandom());
        write_reg(sha1sh_pkg::REG_RC2, $urandom());
        write_reg(sha1sh_pkg::REG_RC3, $urandom());
        write_reg(sha1sh_pkg::REG_MASK, $urandom());
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        run_random_messages(8, 2);
    endtask

    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_digest
        t_digest_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("digest transaction with nothing expected: word %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (o_m_axis_tdata !== want.word) begin
                    $error("digest_word: expected %h, got %h", want.word, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("word_last: expected %b, got %b", want.last, o_m_axis_tlast);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout with %0d digest words outstanding", digest_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_s_axis_tuser  = '0;
        rconst[0] = sha1sh_pkg::RC0_RST;
        rconst[1] = sha1sh_pkg::RC1_RST;
        rconst[2] = sha1sh_pkg::RC2_RST;
        rconst[3] = sha1sh_pkg::RC3_RST;
        mask_en   = 1'b0;
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = '0;
        restart_hash();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_messages();
        test_padding_boundaries();
        test_default_constants();
        test_zero_constants_masked();
        test_ones_constants();
        test_random_constants_no_idle();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("hashed %0d messages from %0d byte/end transactions, %0d digest words checked",
                 messages_done, items_sent, words_checked);
        $display("round constants at reset, all-zero with word masking, all-ones, random");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
